>>> sv/chd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the canonical Huffman bit decoder.
// No dependencies; imported by canonical_huffman_bit_decoder.
package chd_pkg;

  localparam int MAX_LEVELS  = 16;
  localparam int LVL_AW      = $clog2(MAX_LEVELS);
  localparam int LVL_W       = $clog2(MAX_LEVELS + 1);
  localparam int TABLE_DEPTH = 256;
  localparam int TAB_AW      = $clog2(TABLE_DEPTH);
  localparam int SLOT_W      = TAB_AW + 2;
  localparam int CODE_W      = 17;
  localparam int OFS_W       = 9;
  localparam int ROOM_W      = 18;
  localparam int TOTAL_W     = 12;
  localparam int CNT_W       = 8;
  localparam int SYM_W       = 8;
  localparam int CFG_DW      = 9;

  localparam logic [ROOM_W-1:0] INIT_ROOM = ROOM_W'(2);
  localparam logic [LVL_W-1:0]  LEVEL_RST = LVL_W'(16);

  localparam logic CFG_LEVEL_COUNT  = 1'b0;
  localparam logic CFG_SYMBOL_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD_COUNT  = 2'd0,
    ACT_LOAD_SYMBOL = 2'd1,
    ACT_CHECK       = 2'd2,
    ACT_DECODE      = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_ACCEPT    = 3'd0,
    ST_MORE      = 3'd1,
    ST_SYMBOL    = 3'd2,
    ST_LEAVES    = 3'd3,
    ST_MISMATCH  = 3'd4,
    ST_TOOLONG   = 3'd5,
    ST_UNCHECKED = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_DEC,
    S_SYM,
    S_HOLD
  } state_t;

endpackage

>>> sv/canonical_huffman_bit_decoder.sv
`timescale 1ns / 1ps
// Canonical Huffman decoder, one coded bit per transaction, with table check.
// Depends on chd_pkg.
//
// Loads, a decode on an unchecked table and a code-too-long decode finish
// straight from the idle state. A decode bit that needs more bits waits for
// the registered read of the per-length count memory. A decode bit that
// completes a code does the count read, then the registered symbol memory
// read. A table check walks the used levels with one count memory read per
// level. A result sits in an output register, so the next transaction is
// taken while it waits; when the register is still full at the end of an
// item the block holds the result and waits before taking more.
module canonical_huffman_bit_decoder
  import chd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        action,
  input  logic [7:0]        index,
  input  logic [7:0]        data,
  input  logic              bit_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [SYM_W-1:0]  symbol,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  state_t state, state_next;

  logic [LVL_W-1:0]  level_count;
  logic [OFS_W-1:0]  symbol_count;
  logic [LVL_W-1:0]  used_lv;

  // count memory with per-entry valid bits, symbol memory without
  logic [CNT_W-1:0]  count_mem [MAX_LEVELS];
  logic              count_vld [MAX_LEVELS];
  logic [CNT_W-1:0]  cnt_q;
  logic              cnt_rd, cnt_we;
  logic [LVL_AW-1:0] cnt_raddr;
  logic [SYM_W-1:0]  sym_mem [TABLE_DEPTH];
  logic [SYM_W-1:0]  sym_q;
  logic              sym_rd, sym_we;
  logic [TAB_AW-1:0] sym_raddr;

  logic [CODE_W-1:0]  code_accum, code_accum_next;
  logic [CODE_W-1:0]  first_code, first_code_next;
  logic [OFS_W-1:0]   symbol_offset, symbol_offset_next;
  logic [LVL_W-1:0]   walk_level, walk_level_next;
  logic               table_valid, table_valid_next;
  logic [ROOM_W-1:0]  room, room_next;
  logic [TOTAL_W-1:0] total, total_next;
  logic               bit_q;

  logic               res_fire;
  status_t            res_status;
  logic [SYM_W-1:0]   res_symbol;
  status_t            pend_status;
  logic [SYM_W-1:0]   pend_symbol;
  status_t            status_q;
  logic               out_free;

  logic               in_fire, decode_go;
  logic [LVL_W-1:0]   walk_inc;
  logic [CODE_W-1:0]  ca_shift, fc_shift, diff;
  logic [ROOM_W-1:0]  limit, room_sub;
  logic               hit;
  logic [SLOT_W-1:0]  slot;
  logic               slot_ok;
  logic               chk_done, chk_over, mismatch;

  assign used_lv  = (level_count > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : level_count;
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign status   = status_q;

  assign decode_go = (action == ACT_DECODE) && table_valid && (walk_level < used_lv);
  assign walk_inc  = walk_level + LVL_W'(1);

  // decode step arithmetic
  assign ca_shift = {code_accum[CODE_W-2:0], bit_q};
  assign fc_shift = {first_code[CODE_W-2:0], 1'b0};
  assign limit    = {1'b0, fc_shift} + ROOM_W'(cnt_q);
  assign hit      = {1'b0, ca_shift} < limit;
  assign diff     = ca_shift - fc_shift;
  assign slot     = SLOT_W'(diff[CNT_W-1:0]) + SLOT_W'(symbol_offset);
  assign slot_ok  = slot < SLOT_W'(TABLE_DEPTH);
  assign sym_raddr = slot[TAB_AW-1:0];

  // table check arithmetic
  assign chk_done = walk_level >= used_lv;
  assign chk_over = room < ROOM_W'(cnt_q);
  assign room_sub = room - ROOM_W'(cnt_q);
  assign mismatch = (total != TOTAL_W'(symbol_count))
                 || (symbol_count > OFS_W'(TABLE_DEPTH));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (action == ACT_CHECK) state_next = S_CHK;
          else if (decode_go) state_next = S_DEC;
          else if (!out_free) state_next = S_HOLD;
        end
      end
      S_CHK: begin
        if (chk_done || chk_over) state_next = out_free ? S_IDLE : S_HOLD;
      end
      S_DEC: begin
        if (hit && slot_ok) state_next = S_SYM;
        else state_next = out_free ? S_IDLE : S_HOLD;
      end
      S_SYM:   state_next = out_free ? S_IDLE : S_HOLD;
      S_HOLD:  state_next = out_free ? S_IDLE : S_HOLD;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and result selection
  always_comb begin
    res_fire           = 1'b0;
    res_status         = ST_ACCEPT;
    res_symbol         = '0;
    cnt_we             = 1'b0;
    sym_we             = 1'b0;
    cnt_rd             = 1'b0;
    cnt_raddr          = walk_level[LVL_AW-1:0];
    sym_rd             = 1'b0;
    code_accum_next    = code_accum;
    first_code_next    = first_code;
    symbol_offset_next = symbol_offset;
    walk_level_next    = walk_level;
    table_valid_next   = table_valid;
    room_next          = room;
    total_next         = total;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (action)
            ACT_LOAD_COUNT, ACT_LOAD_SYMBOL: begin
              cnt_we             = (action == ACT_LOAD_COUNT) && (index < 8'(MAX_LEVELS));
              sym_we             = (action == ACT_LOAD_SYMBOL)
                                && ({1'b0, index} < 9'(TABLE_DEPTH));
              table_valid_next   = 1'b0;
              code_accum_next    = '0;
              first_code_next    = '0;
              symbol_offset_next = '0;
              walk_level_next    = '0;
              res_fire           = 1'b1;
              res_status         = ST_ACCEPT;
            end
            ACT_CHECK: begin
              // walk_level counts levels during the check
              cnt_rd             = 1'b1;
              cnt_raddr          = '0;
              table_valid_next   = 1'b0;
              code_accum_next    = '0;
              first_code_next    = '0;
              symbol_offset_next = '0;
              walk_level_next    = '0;
              room_next          = INIT_ROOM;
              total_next         = '0;
            end
            ACT_DECODE: begin
              if (!table_valid) begin
                res_fire   = 1'b1;
                res_status = ST_UNCHECKED;
              end else if (!decode_go) begin
                res_fire           = 1'b1;
                res_status         = ST_TOOLONG;
                code_accum_next    = '0;
                first_code_next    = '0;
                symbol_offset_next = '0;
                walk_level_next    = '0;
              end else begin
                cnt_rd = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHK: begin
        if (chk_done) begin
          res_fire         = 1'b1;
          res_status       = mismatch ? ST_MISMATCH : ST_ACCEPT;
          table_valid_next = !mismatch;
          walk_level_next  = '0;
        end else if (chk_over) begin
          res_fire        = 1'b1;
          res_status      = ST_LEAVES;
          walk_level_next = '0;
        end else begin
          total_next      = total + TOTAL_W'(cnt_q);
          room_next       = {room_sub[ROOM_W-2:0], 1'b0};
          walk_level_next = walk_inc;
          cnt_rd          = 1'b1;
          cnt_raddr       = walk_inc[LVL_AW-1:0];
        end
      end
      S_DEC: begin
        if (hit) begin
          code_accum_next    = '0;
          first_code_next    = '0;
          symbol_offset_next = '0;
          walk_level_next    = '0;
          if (slot_ok) begin
            sym_rd = 1'b1;
          end else begin
            res_fire   = 1'b1;
            res_status = ST_SYMBOL;
          end
        end else begin
          code_accum_next    = ca_shift;
          first_code_next    = limit[CODE_W-1:0];
          symbol_offset_next = symbol_offset + OFS_W'(cnt_q);
          walk_level_next    = walk_inc;
          res_fire           = 1'b1;
          res_status         = ST_MORE;
        end
      end
      S_SYM: begin
        res_fire   = 1'b1;
        res_status = ST_SYMBOL;
        res_symbol = sym_q;
      end
      S_HOLD: begin
        res_fire   = 1'b1;
        res_status = pend_status;
        res_symbol = pend_symbol;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      level_count   <= LEVEL_RST;
      symbol_count  <= '0;
      code_accum    <= '0;
      first_code    <= '0;
      symbol_offset <= '0;
      walk_level    <= '0;
      table_valid   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      code_accum    <= code_accum_next;
      first_code    <= first_code_next;
      symbol_offset <= symbol_offset_next;
      walk_level    <= walk_level_next;
      table_valid   <= table_valid_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEVEL_COUNT:  level_count  <= cfg_data[LVL_W-1:0];
          CFG_SYMBOL_COUNT: symbol_count <= cfg_data[OFS_W-1:0];
          default: ;
        endcase
      end
      if (res_fire && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    room  <= room_next;
    total <= total_next;
    if (in_fire) bit_q <= bit_req;
    if (res_fire && out_free) begin
      status_q <= res_status;
      symbol   <= res_symbol;
    end
    if (res_fire && !out_free) begin
      pend_status <= res_status;
      pend_symbol <= res_symbol;
    end
  end

  // count memory: valid bits make unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (cnt_we) count_mem[index[LVL_AW-1:0]] <= data;
    if (cnt_rd) begin
      cnt_q <= count_vld[cnt_raddr] ? count_mem[cnt_raddr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_LEVELS; i++) count_vld[i] <= 1'b0;
    end else if (cnt_we) begin
      count_vld[index[LVL_AW-1:0]] <= 1'b1;
    end
  end

  // symbol memory
  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[index[TAB_AW-1:0]] <= data;
    if (sym_rd) sym_q <= sym_mem[sym_raddr];
  end

`ifndef ASSERT_OFF
  a_valid_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(table_valid) |-> $past(in_fire) && ($past(action) != ACT_DECODE))
    else $error("table_valid dropped without a load or check");

  a_sym_read: assert property (@(posedge clk) disable iff (rst)
    sym_rd |-> (state == S_DEC) && table_valid)
    else $error("symbol read outside a decode step");

  a_sym_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_SYM) |-> $past(state == S_DEC))
    else $error("symbol state entered without a decode step");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_fire && !out_free |=> (state == S_HOLD))
    else $error("result not held while output register full");

  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    cnt_we |-> !cnt_rd && !sym_rd)
    else $error("count memory written and read in one cycle");
`endif

endmodule
